@@ src/cfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the deframer.
// -----------------------------------------------------------------------------
package cfd_pkg;

   localparam int MAX_PAYLOAD_DEF = 48;
   localparam int STORE_DEPTH_DEF = 64;
   localparam int RESULT_CAP      = 48;
   localparam int HEAD_BYTES      = 7;
   localparam int CHECK_BYTES     = 2;
   localparam int CW              = 10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [1:0] CSR_SOF_FIRST = 2'd0;
   localparam logic [1:0] CSR_SOF_SECOND = 2'd1;
   localparam logic [1:0] CSR_VERSION   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_FRAME = 2'd1;
   localparam logic [1:0] ST_BAD_LEN   = 2'd2;

   typedef struct packed {
      logic [7:0] sof_first;
      logic [7:0] sof_second;
      logic [7:0] expected_version;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  node_addr;
      logic [7:0]  command;
      logic [7:0]  sequence_res;
      logic [5:0]  payload_count;
      logic [5:0]  byte_index;
      logic [7:0]  data_byte;
      logic        has_data;
      logic        last;
      logic [31:0] good_total;
      logic [31:0] bad_total;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/cfd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Deframer channel interfaces
// Byte input, result output and register write channels.
// -----------------------------------------------------------------------------
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  node_addr;
   logic [7:0]  command;
   logic [7:0]  sequence_res;
   logic [5:0]  payload_count;
   logic [5:0]  byte_index;
   logic [7:0]  data_byte;
   logic        has_data;
   logic        last;
   logic [31:0] good_total;
   logic [31:0] bad_total;
   modport source (output valid, output status, output node_addr, output command,
                   output sequence_res, output payload_count, output byte_index,
                   output data_byte, output has_data, output last, output good_total,
                   output bad_total, input ready);
   modport sink (input valid, input status, input node_addr, input command,
                 input sequence_res, input payload_count, input byte_index,
                 input data_byte, input has_data, input last, input good_total,
                 input bad_total, output ready);
endinterface

interface cfd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/cfd_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfd_store
// Byte store with one write port and one registered read port.
// -----------------------------------------------------------------------------
module cfd_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ src/cfd_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfd_seq
// Frame sequencer: start-pair hunt, header and CRC pass, result emission.
// -----------------------------------------------------------------------------
module cfd_seq #(
   parameter int MAX_PAYLOAD = 48,
   parameter int STORE_DEPTH = 64,
   parameter int AW = 6,
   parameter int FW = 7
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [7:0]      in_byte,
   input  wire cfd_pkg::cfg_type cfg,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [7:0]           wr_data,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  wire logic [7:0]      rd_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output cfd_pkg::rsp_type     out_data
);
   import cfd_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TOP    = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_HCHK   = 4'd3;
   localparam logic [3:0] S_CRC    = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_BAD    = 4'd6;
   localparam logic [3:0] S_EMPTY  = 4'd7;
   localparam logic [3:0] S_ERD    = 4'd8;
   localparam logic [3:0] S_ECAP   = 4'd9;
   localparam logic [3:0] S_EPUT   = 4'd10;
   localparam logic [3:0] S_DROP   = 4'd11;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
      logic [AW+1:0] s;
      s = {2'b00, base} + (AW+2)'(off);
      if (s >= (AW+2)'(STORE_DEPTH)) begin
         s = s - (AW+2)'(STORE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   ok_cnt_ff, ok_cnt_in;
   logic [31:0]   bad_cnt_ff, bad_cnt_in;
   logic [6:0]    res_cnt_ff, res_cnt_in;
   logic [FW-1:0] iss_ff, iss_in;
   logic [FW-1:0] ret_off_ff, ret_off_in;
   logic          ret_vld_ff, ret_vld_in;
   logic [7:0]    prev_ff, prev_in;
   logic          prev_vld_ff, prev_vld_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    ver_ff, ver_in;
   logic [7:0]    addr_ff, addr_in;
   logic [7:0]    plen_ff, plen_in;
   logic          plen_known_ff, plen_known_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    seq_ff, seq_in;
   logic [7:0]    recv_lo_ff, recv_lo_in;
   logic [7:0]    recv_hi_ff, recv_hi_in;
   logic [1:0]    stat_ff, stat_in;
   logic [FW-1:0] drop_ff, drop_in;
   logic [6:0]    emit_i_ff, emit_i_in;
   logic [7:0]    byte_ff, byte_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic [CW-1:0] total_w;
   logic [CW-1:0] fill_w;
   logic          capped;
   logic          out_free;
   logic          out_ld;
   logic          plen_bad;

   assign total_w  = CW'(HEAD_BYTES + CHECK_BYTES) + {{(CW-8){1'b0}}, plen_ff};
   assign fill_w   = CW'(fill_ff);
   assign capped   = (res_cnt_ff >= 7'(RESULT_CAP));
   assign out_free = !out_valid_ff || out_ready;
   assign plen_bad = (int'(plen_ff) > MAX_PAYLOAD);

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      ok_cnt_in     = ok_cnt_ff;
      bad_cnt_in    = bad_cnt_ff;
      res_cnt_in    = res_cnt_ff;
      iss_in        = iss_ff;
      ret_off_in    = ret_off_ff;
      ret_vld_in    = 1'b0;
      prev_in       = prev_ff;
      prev_vld_in   = prev_vld_ff;
      crc_in        = crc_ff;
      ver_in        = ver_ff;
      addr_in       = addr_ff;
      plen_in       = plen_ff;
      plen_known_in = plen_known_ff;
      cmd_in        = cmd_ff;
      seq_in        = seq_ff;
      recv_lo_in    = recv_lo_ff;
      recv_hi_in    = recv_hi_ff;
      stat_in       = stat_ff;
      drop_in       = drop_ff;
      emit_i_in     = emit_i_ff;
      byte_in       = byte_ff;
      wr_en         = 1'b0;
      wr_addr       = wrap_add(head_ff, fill_ff);
      wr_data       = in_byte;
      rd_en         = 1'b0;
      rd_addr       = wrap_add(head_ff, iss_ff);
      out_ld        = 1'b0;
      out_in        = out_ff;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               wr_en      = 1'b1;
               res_cnt_in = '0;
               state_in   = S_TOP;
               if (fill_ff == FW'(STORE_DEPTH)) begin
                  wr_addr = head_ff;
                  fill_in = FW'(1);
               end else begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         S_TOP: begin
            if (fill_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               iss_in      = '0;
               prev_vld_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (iss_ff < fill_ff) begin
               rd_en      = 1'b1;
               iss_in     = iss_ff + FW'(1);
               ret_vld_in = 1'b1;
               ret_off_in = iss_ff;
            end
            if (ret_vld_ff) begin
               if (prev_vld_ff && prev_ff == cfg.sof_first && rd_data == cfg.sof_second) begin
                  head_in    = wrap_add(head_ff, ret_off_ff - FW'(1));
                  fill_in    = fill_ff - (ret_off_ff - FW'(1));
                  state_in   = S_HCHK;
               end else begin
                  prev_in     = rd_data;
                  prev_vld_in = 1'b1;
               end
            end else if (iss_ff == fill_ff) begin
               head_in  = wrap_add(head_ff, fill_ff - FW'(1));
               fill_in  = FW'(1);
               state_in = S_IDLE;
            end
         end
         S_HCHK: begin
            if (fill_ff < FW'(HEAD_BYTES)) begin
               state_in = S_IDLE;
            end else begin
               iss_in        = FW'(2);
               plen_known_in = 1'b0;
               crc_in        = CRC_INIT;
               state_in      = S_CRC;
            end
         end
         S_CRC: begin
            if (plen_known_ff && plen_bad) begin
               stat_in  = ST_BAD_LEN;
               drop_in  = FW'(1);
               state_in = S_BAD;
            end else if (plen_known_ff && fill_w < total_w) begin
               state_in = S_IDLE;
            end else begin
               if (iss_ff < FW'(HEAD_BYTES) || (plen_known_ff && CW'(iss_ff) < total_w)) begin
                  rd_en      = 1'b1;
                  iss_in     = iss_ff + FW'(1);
                  ret_vld_in = 1'b1;
                  ret_off_in = iss_ff;
               end
               if (ret_vld_ff) begin
                  if (ret_off_ff == FW'(2)) ver_in = rd_data;
                  if (ret_off_ff == FW'(3)) addr_in = rd_data;
                  if (ret_off_ff == FW'(4)) begin
                     plen_in       = rd_data;
                     plen_known_in = 1'b1;
                  end
                  if (ret_off_ff == FW'(5)) cmd_in = rd_data;
                  if (ret_off_ff == FW'(6)) seq_in = rd_data;
                  if (ret_off_ff < FW'(HEAD_BYTES) ||
                      CW'(ret_off_ff) < total_w - CW'(CHECK_BYTES)) begin
                     crc_in = crc_byte(crc_ff, rd_data);
                  end
                  if (plen_known_ff && CW'(ret_off_ff) == total_w - CW'(2)) begin
                     recv_lo_in = rd_data;
                  end
                  if (plen_known_ff && CW'(ret_off_ff) == total_w - CW'(1)) begin
                     recv_hi_in = rd_data;
                     state_in   = S_DECIDE;
                  end
               end
            end
         end
         S_DECIDE: begin
            drop_in = FW'(total_w);
            if (ver_ff != cfg.expected_version || crc_ff != {recv_hi_ff, recv_lo_ff}) begin
               stat_in  = ST_BAD_FRAME;
               state_in = S_BAD;
            end else begin
               ok_cnt_in = ok_cnt_ff + 32'd1;
               emit_i_in = '0;
               state_in  = (plen_ff == 8'd0) ? S_EMPTY : S_ERD;
            end
         end
         S_BAD: begin
            if (capped || out_free) begin
               out_ld            = !capped;
               out_in            = '0;
               out_in.status     = stat_ff;
               out_in.last       = 1'b1;
               out_in.good_total = ok_cnt_ff;
               out_in.bad_total  = bad_cnt_ff + 32'd1;
               bad_cnt_in        = bad_cnt_ff + 32'd1;
               state_in          = S_DROP;
            end
         end
         S_EMPTY: begin
            if (capped || out_free) begin
               out_ld              = !capped;
               out_in              = '0;
               out_in.status       = ST_OK;
               out_in.node_addr    = addr_ff;
               out_in.command      = cmd_ff;
               out_in.sequence_res = seq_ff;
               out_in.last         = 1'b1;
               out_in.good_total   = ok_cnt_ff;
               out_in.bad_total    = bad_cnt_ff;
               state_in            = S_DROP;
            end
         end
         S_ERD: begin
            rd_en    = 1'b1;
            rd_addr  = wrap_add(head_ff, FW'(HEAD_BYTES) + FW'(emit_i_ff));
            state_in = S_ECAP;
         end
         S_ECAP: begin
            byte_in  = rd_data;
            state_in = S_EPUT;
         end
         S_EPUT: begin
            if (capped || out_free) begin
               out_ld               = !capped;
               out_in.status        = ST_OK;
               out_in.node_addr     = addr_ff;
               out_in.command       = cmd_ff;
               out_in.sequence_res  = seq_ff;
               out_in.payload_count = plen_ff[5:0];
               out_in.byte_index    = emit_i_ff[5:0];
               out_in.data_byte     = byte_ff;
               out_in.has_data      = 1'b1;
               out_in.last          = ({1'b0, emit_i_ff} + 8'd1 == plen_ff);
               out_in.good_total    = ok_cnt_ff;
               out_in.bad_total     = bad_cnt_ff;
               emit_i_in            = emit_i_ff + 7'd1;
               state_in = ({1'b0, emit_i_ff} + 8'd1 == plen_ff) ? S_DROP : S_ERD;
            end
         end
         S_DROP: begin
            head_in    = wrap_add(head_ff, drop_ff);
            fill_in    = fill_ff - drop_ff;
            state_in   = S_TOP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_ld) begin
         res_cnt_in   = res_cnt_ff + 7'd1;
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         ok_cnt_ff    <= '0;
         bad_cnt_ff   <= '0;
         res_cnt_ff   <= '0;
         ret_vld_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         ok_cnt_ff    <= ok_cnt_in;
         bad_cnt_ff   <= bad_cnt_in;
         res_cnt_ff   <= res_cnt_in;
         ret_vld_ff   <= ret_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      ret_off_ff    <= ret_off_in;
      prev_ff       <= prev_in;
      prev_vld_ff   <= prev_vld_in;
      crc_ff        <= crc_in;
      ver_ff        <= ver_in;
      addr_ff       <= addr_in;
      plen_ff       <= plen_in;
      plen_known_ff <= plen_known_in;
      cmd_ff        <= cmd_in;
      seq_ff        <= seq_in;
      recv_lo_ff    <= recv_lo_in;
      recv_hi_ff    <= recv_hi_in;
      stat_ff       <= stat_in;
      drop_ff       <= drop_in;
      emit_i_ff     <= emit_i_in;
      byte_ff       <= byte_in;
      if (out_ld) begin
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

@@ src/crc16_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// crc16_frame_deframer_unit
// Start-pair, length and CRC-16/MODBUS checking deframer over a byte store.
// -----------------------------------------------------------------------------
// Each byte transfer starts a pass that rescans the store at one read per cycle to find
// the start pair, then reads the header and CRC of a complete frame; each payload result
// is read from the store, captured and then offered on the output.
// One byte is taken per pass; output stalls hold the input off. Reset clears the fill
// count, the counters and the output but not the store, and sets the registers to 0xAA,
// 0x55 and version 1.
module crc16_frame_deframer_unit #(
   parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF,
   parameter int STORE_DEPTH = cfd_pkg::STORE_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   cfd_req_if.sink    req_ch,
   cfd_rsp_if.source  rsp_ch,
   cfd_csr_if.sink    csr_ch
);
   import cfd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int FW = $clog2(STORE_DEPTH + 1);

   cfg_type       cfg_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   rsp_type       rsp;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sof_first        <= 8'hAA;
         cfg_ff.sof_second       <= 8'h55;
         cfg_ff.expected_version <= 8'h01;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SOF_FIRST:  cfg_ff.sof_first        <= csr_ch.data;
            CSR_SOF_SECOND: cfg_ff.sof_second       <= csr_ch.data;
            CSR_VERSION:    cfg_ff.expected_version <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   cfd_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfd_seq #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW),
      .FW          (FW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_byte   (req_ch.in_byte),
      .cfg       (cfg_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp)
   );

   assign rsp_ch.status        = rsp.status;
   assign rsp_ch.node_addr     = rsp.node_addr;
   assign rsp_ch.command       = rsp.command;
   assign rsp_ch.sequence_res  = rsp.sequence_res;
   assign rsp_ch.payload_count = rsp.payload_count;
   assign rsp_ch.byte_index    = rsp.byte_index;
   assign rsp_ch.data_byte     = rsp.data_byte;
   assign rsp_ch.has_data      = rsp.has_data;
   assign rsp_ch.last          = rsp.last;
   assign rsp_ch.good_total    = rsp.good_total;
   assign rsp_ch.bad_total     = rsp.bad_total;
endmodule
`default_nettype wire

@@ tb/crc16_frame_deframer_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// crc16_frame_deframer_unit_tb
// Feeds byte streams of good, corrupted, overlong and noisy frames into the
// deframer under several start-pair and version settings. A local frame
// tracker predicts every payload and status result, which is checked field by
// field in order while both channels idle and stall at random.
// -----------------------------------------------------------------------------
module crc16_frame_deframer_unit_tb;
   import cfd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfd_req_if req_ch ();
   cfd_rsp_if rsp_ch ();
   cfd_csr_if csr_ch ();

   crc16_frame_deframer_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   typedef struct {
      logic [7:0] value;
      logic       typed;
      logic [1:0] status;
   } byte_row_type;

   logic [7:0]  frame_buf [0:STORE_DEPTH_DEF-1];
   int          buf_fill;
   logic [31:0] ok_frames;
   logic [31:0] bad_frames;
   cfg_type     link_cfg;
   rsp_type     pending_rsp [$];
   logic [1:0]  typed_status [$];
   int          mismatches;
   int          frames_seen;
   int          bytes_sent;
   int          hold_off;
   logic        stall_mode;
   logic [7:0]  frame_bytes [$];
   byte_row_type directed [$];

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic shift_out(input int k);
      if (k >= buf_fill) begin
         buf_fill = 0;
      end else begin
         for (int i = 0; i < buf_fill - k; i++) begin
            frame_buf[i] = frame_buf[i + k];
         end
         buf_fill -= k;
      end
   endtask

   task automatic add_rsp(inout int cnt, input rsp_type r);
      if (cnt < RESULT_CAP) begin
         r.good_total = ok_frames;
         r.bad_total  = bad_frames;
         pending_rsp.push_back(r);
         cnt++;
      end
   endtask

   task automatic track_byte(input logic [7:0] b);
      int          cnt;
      int          start;
      int          plen;
      int          total;
      logic        found;
      logic [15:0] crc;
      logic [15:0] recv;
      rsp_type     r;
      cnt = 0;
      if (buf_fill >= STORE_DEPTH_DEF) buf_fill = 0;
      frame_buf[buf_fill] = b;
      buf_fill++;
      while (buf_fill > 0) begin
         found = 1'b0;
         start = 0;
         for (int i = 0; i + 1 < buf_fill && !found; i++) begin
            if (frame_buf[i] == link_cfg.sof_first && frame_buf[i+1] == link_cfg.sof_second) begin
               start = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            frame_buf[0] = frame_buf[buf_fill - 1];
            buf_fill = 1;
            break;
         end
         shift_out(start);
         if (buf_fill < HEAD_BYTES) break;
         plen = int'(frame_buf[4]);
         r = '0;
         r.last = 1'b1;
         if (plen > MAX_PAYLOAD_DEF) begin
            bad_frames++;
            r.status = ST_BAD_LEN;
            add_rsp(cnt, r);
            shift_out(1);
            continue;
         end
         total = HEAD_BYTES + plen + CHECK_BYTES;
         if (buf_fill < total) break;
         crc = CRC_INIT;
         for (int i = 2; i < HEAD_BYTES + plen; i++) crc = crc_step(crc, frame_buf[i]);
         recv = {frame_buf[total - 1], frame_buf[total - 2]};
         if (frame_buf[2] != link_cfg.expected_version || crc != recv) begin
            bad_frames++;
            r.status = ST_BAD_FRAME;
            add_rsp(cnt, r);
         end else begin
            ok_frames++;
            r.status       = ST_OK;
            r.node_addr    = frame_buf[3];
            r.command      = frame_buf[5];
            r.sequence_res = frame_buf[6];
            if (plen == 0) begin
               add_rsp(cnt, r);
            end else begin
               for (int i = 0; i < plen; i++) begin
                  r.payload_count = plen[5:0];
                  r.byte_index    = i[5:0];
                  r.data_byte     = frame_buf[HEAD_BYTES + i];
                  r.has_data      = 1'b1;
                  r.last          = (i + 1 == plen);
                  add_rsp(cnt, r);
               end
            end
         end
         shift_out(total);
      end
   endtask

   // Builds one frame into frame_bytes; flaw 1 corrupts the CRC, 2 the version.
   task automatic build_frame(input int plen, input int flaw);
      logic [15:0] crc;
      logic [7:0]  body [$];
      body = {};
      body.push_back(flaw == 2 ? link_cfg.expected_version ^ 8'h01 : link_cfg.expected_version);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(plen[7:0]);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < plen; i++) body.push_back(8'($urandom_range(0, 255)));
      crc = CRC_INIT;
      foreach (body[i]) crc = crc_step(crc, body[i]);
      if (flaw == 1) crc ^= 16'h0001 << $urandom_range(0, 15);
      frame_bytes.push_back(link_cfg.sof_first);
      frame_bytes.push_back(link_cfg.sof_second);
      foreach (body[i]) frame_bytes.push_back(body[i]);
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] st);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      track_byte(b);
      if (typed && pending_rsp.size() > 0) typed_status.push_back(st);
      bytes_sent++;
      if ($urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_frame_bytes();
      while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front(), 1'b0, ST_OK);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_SOF_FIRST:  link_cfg.sof_first = val;
         CSR_SOF_SECOND: link_cfg.sof_second = val;
         default:        link_cfg.expected_version = val;
      endcase
   endtask

   task automatic random_traffic(input int n);
      int kind;
      for (int f = 0; f < n; f++) begin
         kind = $urandom_range(0, 19);
         if (kind < 12) begin
            build_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 48)
                                                    : $urandom_range(0, 6), 0);
         end else if (kind < 15) begin
            build_frame($urandom_range(0, 5), $urandom_range(1, 2));
         end else if (kind < 17) begin
            frame_bytes.push_back(link_cfg.sof_first);
            frame_bytes.push_back(link_cfg.sof_second);
            repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(8'($urandom_range(49, 255)));
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_frame_bytes();
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode   <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result transfer at %0t", $realtime);
            end else begin
               exp = pending_rsp.pop_front();
               if (typed_status.size() > 0 && exp.last) begin
                  if (typed_status.pop_front() != rsp_ch.status) begin
                     mismatches++;
                     if (mismatches <= 10) $display("Status differs from the table row");
                  end
               end
               if (rsp_ch.status !== exp.status || rsp_ch.node_addr !== exp.node_addr ||
                   rsp_ch.command !== exp.command ||
                   rsp_ch.sequence_res !== exp.sequence_res ||
                   rsp_ch.payload_count !== exp.payload_count ||
                   rsp_ch.byte_index !== exp.byte_index ||
                   rsp_ch.data_byte !== exp.data_byte || rsp_ch.has_data !== exp.has_data ||
                   rsp_ch.last !== exp.last || rsp_ch.good_total !== exp.good_total ||
                   rsp_ch.bad_total !== exp.bad_total) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch expected st=%0d a=%h c=%h s=%h n=%0d i=%0d d=%h h=%b l=%b g=%0d b=%0d",
                              exp.status, exp.node_addr, exp.command, exp.sequence_res,
                              exp.payload_count, exp.byte_index, exp.data_byte,
                              exp.has_data, exp.last, exp.good_total, exp.bad_total);
                     $display("         actual   st=%0d a=%h c=%h s=%h n=%0d i=%0d d=%h h=%b l=%b g=%0d b=%0d",
                              rsp_ch.status, rsp_ch.node_addr, rsp_ch.command,
                              rsp_ch.sequence_res, rsp_ch.payload_count, rsp_ch.byte_index,
                              rsp_ch.data_byte, rsp_ch.has_data, rsp_ch.last,
                              rsp_ch.good_total, rsp_ch.bad_total);
                  end
               end
               if (exp.last) frames_seen++;
            end
         end
         if (hold_off > 0) begin
            hold_off     <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 31) == 0) stall_mode <= ~stall_mode;
            rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL crc16_frame_deframer_unit");
      $finish;
   end

   initial begin
      int n;
      logic [15:0] crc;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_SOF_FIRST;
      csr_ch.data    = 8'h00;
      rsp_ch.ready   = 1'b0;
      buf_fill = 0;
      ok_frames = '0;
      bad_frames = '0;
      mismatches = 0;
      frames_seen = 0;
      bytes_sent = 0;
      hold_off = 0;
      link_cfg = '{sof_first: 8'hAA, sof_second: 8'h55, expected_version: 8'h01};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: noise, empty frame, overlong length, bad version; then a full-length frame and a bad-CRC frame.
      crc = crc_step(crc_step(crc_step(crc_step(crc_step(CRC_INIT, 8'h01), 8'h00),
                     8'h00), 8'h00), 8'h00);
      directed = '{
         '{8'h00, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK}, '{8'hAA, 1'b0, ST_OK},
         '{8'h55, 1'b0, ST_OK}, '{8'h01, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
         '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
         '{crc[7:0], 1'b0, ST_OK}, '{crc[15:8], 1'b1, ST_OK},
         '{8'hAA, 1'b0, ST_OK}, '{8'h55, 1'b0, ST_OK}, '{8'h01, 1'b0, ST_OK},
         '{8'h00, 1'b0, ST_OK}, '{8'hFF, 1'b1, ST_BAD_LEN},
         '{8'hAA, 1'b0, ST_OK}, '{8'h55, 1'b0, ST_OK}, '{8'h07, 1'b0, ST_OK},
         '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
         '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b1, ST_BAD_FRAME}
      };
      foreach (directed[i]) send_byte(directed[i].value, directed[i].typed, directed[i].status);
      build_frame(48, 0);
      build_frame(1, 1);
      send_frame_bytes();
      wait_drained();

      // Receiver holds off while the sender keeps offering a second frame.
      hold_off = 1500;
      build_frame(6, 0);
      build_frame(2, 0);
      send_frame_bytes();
      wait_drained();

      random_traffic(1);
      wait_drained();
      write_csr(CSR_SOF_FIRST, 8'h00);
      write_csr(CSR_SOF_SECOND, 8'hFF);
      write_csr(CSR_VERSION, 8'hFF);
      random_traffic(1);
      wait_drained();
      write_csr(CSR_SOF_FIRST, 8'hFF);
      write_csr(CSR_SOF_SECOND, 8'h00);
      write_csr(CSR_VERSION, 8'h00);
      random_traffic(1);
      wait_drained();
      write_csr(CSR_SOF_FIRST, 8'h5A);
      write_csr(CSR_SOF_SECOND, 8'h5A);
      write_csr(CSR_VERSION, 8'($urandom_range(0, 255)));
      random_traffic(1);
      wait_drained();
      write_csr(CSR_SOF_FIRST, 8'hAA);
      write_csr(CSR_SOF_SECOND, 8'h55);
      write_csr(CSR_VERSION, 8'h01);
      // A noise run without a start pair keeps only the newest byte.
      n = 0;
      while (n < 12) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, ST_OK);
         n++;
      end
      random_traffic(1);
      wait_drained();

      $display("Sent %0d bytes under five register settings; %0d frame decisions checked.",
               bytes_sent, frames_seen);
      $display("Good frames %0d, rejected frames %0d, mismatches %0d.",
               ok_frames, bad_frames, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASS crc16_frame_deframer_unit");
      end else begin
         $display("FAIL crc16_frame_deframer_unit");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
src/cfd_pkg.sv
src/cfd_if.sv
src/cfd_store.sv
src/cfd_seq.sv
src/crc16_frame_deframer_unit.sv
tb/crc16_frame_deframer_unit_tb.sv
